>>> rtl/core/first_fit_coalescing_allocator_macros.svh
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define FFCA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFCA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ffca_pkg.sv
`timescale 1ns / 1ps
package ffca_pkg;

    localparam int MAX_RANGES_DEF = 16;
    localparam int ADDR_BITS_DEF  = 32;

    localparam logic [31:0] TOTAL_RESET = 32'd16384;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_ALLOC  = 3'd2;
    localparam logic [2:0] OP_SORT   = 3'd3;
    localparam logic [2:0] OP_MERGE  = 3'd4;
    localparam logic [2:0] OP_COMMIT = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic       parity;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic at_end;
        logic merge_eq;
        logic merge_done;
    } t_sts;

endpackage

>>> rtl/core/first_fit_coalescing_allocator.sv
`timescale 1ns / 1ps
// An allocate scans the free ranges from index 0 until one fits (status OK) or the table ends (NOFIT);
//   a free loads the range into a window, sorts it by odd-even passes, merges, then commits.
// One word at a time: the next is taken once busy drops.
// Result strobe o_done lasts one cycle; the receiver cannot stall it.
// Synchronous reset: table is the one range [0, 16384), used amount 0, block idle.
module first_fit_coalescing_allocator
    import ffca_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [31:0] i_size,
    input  logic [31:0] i_address,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [31:0] o_start_address,
    output logic [31:0] o_used_amount
);

`include "first_fit_coalescing_allocator_macros.svh"

    localparam int CW = $clog2(MAX_RANGES + 2);

    logic [31:0]   r_total;
    logic          cfg_we;
    t_cmd          cmd;
    t_sts          sts;
    logic [CW-1:0] idx;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? r_total : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RESET;
        end else if (cfg_we) begin
            r_total <= pwdata;
        end
    end

    ffca_ctrl #(
        .MAX_RANGES (MAX_RANGES),
        .CW         (CW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .o_idx   (idx)
    );

    ffca_dp #(
        .MAX_RANGES (MAX_RANGES),
        .ADDR_BITS  (ADDR_BITS),
        .CW         (CW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .i_size      (i_size),
        .i_address   (i_address),
        .i_cfg_we    (cfg_we),
        .i_cfg_total (pwdata),
        .o_sts       (sts),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_start     (o_start_address),
        .o_used      (o_used_amount)
    );

    `FFCA_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
    `FFCA_ASSERT_NOW(a_done_after_busy, o_done, $past(busy), "result without a request in flight")
    `FFCA_ASSERT_NOW(a_nofit_zero, o_done && (o_status == ST_NOFIT), o_start_address == 32'd0, "failed allocate returned an address")

endmodule

>>> rtl/core/ffca_ctrl.sv
`timescale 1ns / 1ps
module ffca_ctrl
    import ffca_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF,
    parameter int CW         = $clog2(MAX_RANGES + 2)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_kind,
    input  t_sts          i_sts,
    output logic          o_busy,
    output t_cmd          o_cmd,
    output logic [CW-1:0] o_idx
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ALLOC  = 3'd1;
    localparam logic [2:0] S_SORT   = 3'd2;
    localparam logic [2:0] S_MERGE  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_cmd.op     = OP_NONE;
        o_cmd.parity = r_idx[0];
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_idx    = '0;
                    n_state  = i_kind ? S_SORT : S_ALLOC;
                end
            end
            S_ALLOC: begin
                o_cmd.op = OP_ALLOC;
                if (i_sts.hit || i_sts.at_end) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_SORT: begin
                // odd-even transposition, one pass a cycle, MAX_RANGES+1 passes
                o_cmd.op = OP_SORT;
                if (r_idx == CW'(MAX_RANGES)) begin
                    n_idx   = '0;
                    n_state = S_MERGE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_MERGE: begin
                // stay on an entry while it absorbs its successor
                o_cmd.op = OP_MERGE;
                if (i_sts.merge_done) begin
                    n_state = S_COMMIT;
                end else if (!i_sts.merge_eq) begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_COMMIT: begin
                o_cmd.op = OP_COMMIT;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_idx  = r_idx;

endmodule

>>> rtl/core/ffca_dp.sv
`timescale 1ns / 1ps
module ffca_dp
    import ffca_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int CW         = $clog2(MAX_RANGES + 2)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [CW-1:0] i_idx,
    input  logic [31:0]   i_size,
    input  logic [31:0]   i_address,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_total,
    output t_sts          o_sts,
    output logic          o_done,
    output logic [1:0]    o_status,
    output logic [31:0]   o_start,
    output logic [31:0]   o_used
);

    localparam int AW = ADDR_BITS;
    localparam int EW = AW + 1;
    localparam int XW = ((AW > 32) ? AW : 32) + 1;
    localparam int TI = $clog2(MAX_RANGES);
    localparam int WN = MAX_RANGES + 1;
    localparam logic [XW-1:0] LIMIT_X = XW'(1) << AW;

    function automatic logic [EW-1:0] clamp_end(input logic [XW-1:0] v);
        clamp_end = (v > LIMIT_X) ? EW'(LIMIT_X) : EW'(v);
    endfunction

    logic [AW-1:0] r_ts [MAX_RANGES];
    logic [EW-1:0] r_te [MAX_RANGES];
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_ws [WN];
    logic [EW-1:0] r_we [WN];
    logic [CW-1:0] r_wn;
    logic [31:0]   r_size;
    logic [31:0]   r_used;
    logic          r_done;
    logic [1:0]    r_status;
    logic [31:0]   r_start;

    logic [TI-1:0]         ti;
    logic [EW-1:0]         len;
    logic                  exact;
    logic [MAX_RANGES-1:0] eqv;
    logic [EW-1:0]         free_end;
    logic [32:0]           used_add;
    logic [31:0]           used_sub;

    assign ti    = i_idx[TI-1:0];
    assign len   = r_te[ti] - {1'b0, r_ts[ti]};
    assign exact = (XW'(len) == XW'(r_size));

    always_comb begin
        for (int j = 0; j < MAX_RANGES; j++) begin
            eqv[j] = (r_we[j] == {1'b0, r_ws[j+1]});
        end
    end

    assign o_sts.at_end     = (i_idx >= r_cnt);
    assign o_sts.hit        = !o_sts.at_end && (XW'(len) >= XW'(r_size));
    assign o_sts.merge_done = ((i_idx + CW'(1)) >= r_wn);
    assign o_sts.merge_eq   = eqv[ti];

    assign free_end = clamp_end(XW'(AW'(i_address)) + XW'(i_size));
    assign used_add = {1'b0, r_used} + {1'b0, r_size};
    assign used_sub = (r_used >= r_size) ? (r_used - r_size) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts[0] <= '0;
            r_te[0] <= clamp_end(XW'(TOTAL_RESET));
            r_cnt   <= CW'(1);
            r_used  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_ts[0] <= '0;
                r_te[0] <= clamp_end(XW'(i_cfg_total));
                r_cnt   <= CW'(1);
                r_used  <= '0;
            end else begin
                case (i_cmd.op)
                    OP_LOAD: begin
                        r_size <= i_size;
                        for (int k = 0; k < MAX_RANGES; k++) begin
                            if (CW'(k) == r_cnt) begin
                                r_ws[k] <= AW'(i_address);
                                r_we[k] <= free_end;
                            end else begin
                                r_ws[k] <= r_ts[k];
                                r_we[k] <= r_te[k];
                            end
                        end
                        // spare slot, only inside the window when the table is full
                        r_ws[WN-1] <= AW'(i_address);
                        r_we[WN-1] <= free_end;
                        r_wn <= r_cnt + CW'(1);
                    end
                    OP_ALLOC: begin
                        if (o_sts.hit) begin
                            r_done   <= 1'b1;
                            r_status <= ST_OK;
                            r_start  <= 32'(r_ts[ti]);
                            r_used   <= used_add[32] ? 32'hFFFF_FFFF : used_add[31:0];
                            if (exact) begin
                                for (int j = 0; j < MAX_RANGES - 1; j++) begin
                                    if (CW'(j) >= i_idx) begin
                                        r_ts[j] <= r_ts[j+1];
                                        r_te[j] <= r_te[j+1];
                                    end
                                end
                                r_cnt <= r_cnt - CW'(1);
                            end else begin
                                r_ts[ti] <= AW'(XW'(r_ts[ti]) + XW'(r_size));
                            end
                        end else if (o_sts.at_end) begin
                            r_done   <= 1'b1;
                            r_status <= ST_NOFIT;
                            r_start  <= '0;
                        end
                    end
                    OP_SORT: begin
                        for (int j = 0; j < WN - 1; j++) begin
                            if ((j[0] == i_cmd.parity) && (CW'(j + 1) < r_wn)
                                && ((r_ws[j] > r_ws[j+1])
                                    || ((r_ws[j] == r_ws[j+1])
                                        && (r_we[j] > r_we[j+1])))) begin
                                r_ws[j]   <= r_ws[j+1];
                                r_we[j]   <= r_we[j+1];
                                r_ws[j+1] <= r_ws[j];
                                r_we[j+1] <= r_we[j];
                            end
                        end
                    end
                    OP_MERGE: begin
                        if (!o_sts.merge_done && o_sts.merge_eq) begin
                            for (int j = 0; j < WN - 1; j++) begin
                                if (CW'(j) == i_idx) begin
                                    r_we[j] <= r_we[j+1];
                                end else if (CW'(j) > i_idx) begin
                                    r_ws[j] <= r_ws[j+1];
                                    r_we[j] <= r_we[j+1];
                                end
                            end
                            r_wn <= r_wn - CW'(1);
                        end
                    end
                    OP_COMMIT: begin
                        r_done  <= 1'b1;
                        r_start <= '0;
                        if (r_wn > CW'(MAX_RANGES)) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_status <= ST_OK;
                            for (int k = 0; k < MAX_RANGES; k++) begin
                                r_ts[k] <= r_ws[k];
                                r_te[k] <= r_we[k];
                            end
                            r_cnt  <= r_wn;
                            r_used <= used_sub;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_start  = r_start;
    assign o_used   = r_used;

endmodule

>>> verif/first_fit_coalescing_allocator_tb.sv
`timescale 1ns / 1ps
module first_fit_coalescing_allocator_tb;
    import ffca_pkg::*;

    localparam int          SLOTS      = 16;
    localparam longint      SPACE_TOP  = 64'h1_0000_0000;
    localparam logic        KIND_ALLOC = 1'b0;
    localparam logic        KIND_FREE  = 1'b1;
    localparam logic [2:0]  REG_TOTAL  = 3'd0;

    typedef struct {
        logic        kind;
        logic [31:0] size;
        logic [31:0] addr;
    } t_req;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] start_addr;
        logic [31:0] used;
    } t_resp;

    typedef struct {
        logic [31:0] addr;
        logic [31:0] size;
    } t_block;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic        i_kind = 1'b0;
    logic [31:0] i_size = '0;
    logic [31:0] i_address = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [31:0] o_start_address;
    logic [31:0] o_used_amount;

    first_fit_coalescing_allocator uut (.*);

    always #4 i_clk = ~i_clk;

    t_req   pending_reqs[$];
    t_resp  expected_resps[$];
    t_block live_blocks[$];
    int     errors = 0;
    bit     calm = 1'b0;

    // free-range table as the block should hold it
    longint unsigned range_lo[SLOTS];
    longint unsigned range_hi[SLOTS];
    int              range_cnt;
    longint unsigned used_sum;

    function automatic void table_init(input logic [31:0] total);
        range_lo[0] = 0;
        range_hi[0] = total;
        range_cnt   = 1;
        used_sum    = 0;
    endfunction

    function automatic t_resp predict_alloc(input logic [31:0] size);
        t_resp r;
        longint unsigned len;
        r = '{ST_NOFIT, 32'd0, used_sum[31:0]};
        for (int i = 0; i < range_cnt; i++) begin
            len = range_hi[i] - range_lo[i];
            if (len >= size) begin
                r.status     = ST_OK;
                r.start_addr = range_lo[i][31:0];
                if (len == size) begin
                    for (int j = i; j + 1 < range_cnt; j++) begin
                        range_lo[j] = range_lo[j + 1];
                        range_hi[j] = range_hi[j + 1];
                    end
                    range_cnt--;
                end else begin
                    range_lo[i] += size;
                end
                used_sum += size;
                if (used_sum > 64'hFFFF_FFFF) used_sum = 64'hFFFF_FFFF;
                r.used = used_sum[31:0];
                break;
            end
        end
        return r;
    endfunction

    function automatic t_resp predict_free(input logic [31:0] addr, input logic [31:0] size);
        longint unsigned lo[SLOTS + 1];
        longint unsigned hi[SLOTS + 1];
        longint unsigned ks, ke;
        int n, i, j;
        n = range_cnt;
        for (i = 0; i < n; i++) begin
            lo[i] = range_lo[i];
            hi[i] = range_hi[i];
        end
        lo[n] = addr;
        hi[n] = longint'(addr) + longint'(size);
        if (hi[n] > SPACE_TOP) hi[n] = SPACE_TOP;
        n++;
        for (i = 1; i < n; i++) begin
            ks = lo[i];
            ke = hi[i];
            j = i;
            while (j > 0 && (lo[j - 1] > ks || (lo[j - 1] == ks && hi[j - 1] > ke))) begin
                lo[j] = lo[j - 1];
                hi[j] = hi[j - 1];
                j--;
            end
            lo[j] = ks;
            hi[j] = ke;
        end
        i = 0;
        while (i + 1 < n) begin
            if (hi[i] == lo[i + 1]) begin
                hi[i] = hi[i + 1];
                for (j = i + 1; j + 1 < n; j++) begin
                    lo[j] = lo[j + 1];
                    hi[j] = hi[j + 1];
                end
                n--;
            end else begin
                i++;
            end
        end
        if (n > SLOTS) return '{ST_FULL, 32'd0, used_sum[31:0]};
        for (i = 0; i < n; i++) begin
            range_lo[i] = lo[i];
            range_hi[i] = hi[i];
        end
        range_cnt = n;
        used_sum = (used_sum >= size) ? used_sum - size : 0;
        return '{ST_OK, 32'd0, used_sum[31:0]};
    endfunction

    task automatic issue(input logic kind, input logic [31:0] size, input logic [31:0] addr);
        t_resp  r;
        t_req   q;
        t_block b;
        if (kind == KIND_ALLOC) begin
            r = predict_alloc(size);
            if (r.status == ST_OK && size != 0) begin
                b.addr = r.start_addr;
                b.size = size;
                live_blocks.insert(live_blocks.size(), b);
            end
        end else begin
            r = predict_free(addr, size);
        end
        q.kind = kind;
        q.size = size;
        q.addr = addr;
        pending_reqs.insert(pending_reqs.size(), q);
        expected_resps.insert(expected_resps.size(), r);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_resps.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_total(input logic [31:0] value);
        drain();
        repeat (40) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_TOTAL;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        table_init(value);
        live_blocks.delete();
    endtask

    task automatic random_phase(input int count, input logic [31:0] small_max);
        int pick, idx;
        t_block b;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                issue(KIND_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom()
                                   : $urandom_range(0, small_max), $urandom());
            end else if (pick < 88 && live_blocks.size() != 0) begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                b = live_blocks[idx];
                live_blocks.delete(idx);
                issue(KIND_FREE, b.size, b.addr);
            end else begin
                issue(KIND_FREE, ($urandom_range(0, 3) == 0) ? $urandom()
                                  : $urandom_range(0, small_max), $urandom());
            end
        end
        drain();
    endtask

    // driver: the head of the queue is dropped once its word is taken
    always @(posedge i_clk) begin
        if (start && !busy) pending_reqs.pop_front();
        if (i_rst_n && pending_reqs.size() != 0
                && (calm || $urandom_range(0, 99) >= 35)) begin
            t_req q;
            q = pending_reqs[0];
            start     <= 1'b1;
            i_kind    <= q.kind;
            i_size    <= q.size;
            i_address <= q.addr;
        end else begin
            start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_resps.size() == 0) begin
                $display("%0t: unexpected result status=%0d start=%h used=%h",
                         $time, o_status, o_start_address, o_used_amount);
                errors++;
            end else begin
                t_resp e;
                e = expected_resps.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, o_status);
                    errors++;
                end
                if (o_start_address !== e.start_addr) begin
                    $display("%0t: start_address expected %h actual %h",
                             $time, e.start_addr, o_start_address);
                    errors++;
                end
                if (o_used_amount !== e.used) begin
                    $display("%0t: used_amount expected %h actual %h",
                             $time, e.used, o_used_amount);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        table_init(TOTAL_RESET);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero-size, exact fit, empty table, zero-size free
        issue(KIND_ALLOC, 32'd0, 32'hFFFF_FFFF);
        issue(KIND_ALLOC, 32'd100, 32'd0);
        issue(KIND_ALLOC, 32'd16284, 32'd0);
        issue(KIND_ALLOC, 32'd1, 32'd0);
        issue(KIND_ALLOC, 32'd0, 32'd0);
        issue(KIND_FREE, 32'd0, 32'd50);
        issue(KIND_FREE, 32'd100, 32'd0);
        issue(KIND_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // table overflow: seventeen separate fragments
        write_total(32'd64);
        issue(KIND_ALLOC, 32'd64, 32'd0);
        for (int i = 0; i < 17; i++) issue(KIND_FREE, 32'd1, 32'(2 * i));
        issue(KIND_FREE, 32'd1, 32'd1);
        drain();

        // full space, used count up to its top, free end clamped at the top of the space
        write_total(32'hFFFF_FFFF);
        issue(KIND_ALLOC, 32'hFFFF_FFF0, 32'd0);
        issue(KIND_ALLOC, 32'hF, 32'd0);
        issue(KIND_FREE, 32'hFFFF_FFFF, 32'h8000_0000);
        issue(KIND_ALLOC, 32'h7FFF_FFFF, 32'd0);
        issue(KIND_ALLOC, 32'h8000_0000, 32'd0);
        drain();

        write_total(32'd0);
        issue(KIND_ALLOC, 32'd0, 32'd0);
        issue(KIND_ALLOC, 32'd0, 32'd0);
        issue(KIND_ALLOC, 32'd1, 32'd0);
        drain();

        write_total(32'd1);
        random_phase(120, 2);
        write_total(TOTAL_RESET);
        random_phase(250, 1024);
        calm = 1'b1;
        random_phase(200, 512);
        calm = 1'b0;
        write_total(32'd200);
        random_phase(200, 40);
        write_total(32'hFFFF_FFFF);
        random_phase(200, 32'h00FF_FFFF);
        write_total(32'd4096);
        random_phase(150, 300);

        drain();
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ffca_pkg.sv
rtl/core/ffca_ctrl.sv
rtl/core/ffca_dp.sv
rtl/core/first_fit_coalescing_allocator.sv
verif/first_fit_coalescing_allocator_tb.sv
